FILE: rtl/hcbd_pkg.sv
// Shared types and constants for the HTTP chunked body decoder.
package hcbd_pkg;

    // Parser phases; an error is held as PH_ERR0 plus its code
    localparam logic [3:0] PH_PRE  = 4'd0;
    localparam logic [3:0] PH_DIG  = 4'd1;
    localparam logic [3:0] PH_POST = 4'd2;
    localparam logic [3:0] PH_EXT  = 4'd3;
    localparam logic [3:0] PH_HCR  = 4'd4;
    localparam logic [3:0] PH_DATA = 4'd5;
    localparam logic [3:0] PH_DCR  = 4'd6;
    localparam logic [3:0] PH_DLF  = 4'd7;
    localparam logic [3:0] PH_TRL  = 4'd8;
    localparam logic [3:0] PH_TCR  = 4'd9;
    localparam logic [3:0] PH_DONE = 4'd10;
    localparam logic [3:0] PH_ERR0 = 4'd10;

    // Result kinds
    localparam logic [1:0] K_FRAME = 2'd0;
    localparam logic [1:0] K_DATA  = 2'd1;
    localparam logic [1:0] K_DONE  = 2'd2;
    localparam logic [1:0] K_ERR   = 2'd3;

    // Error codes
    localparam logic [2:0] E_NONE = 3'd0;
    localparam logic [2:0] E_CRLF = 3'd1;
    localparam logic [2:0] E_HDR  = 3'd2;
    localparam logic [2:0] E_SIZE = 3'd3;
    localparam logic [2:0] E_END  = 3'd4;

    // Framing characters
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_SEMI = 8'h3B;

    // Register indexes
    localparam logic REG_MAX_SIZE = 1'b0;
    localparam logic REG_STRICT   = 1'b1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       stream_end;
        logic       start_message;
    } in_beat_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] payload;
        logic       chunk_last;
        logic [2:0] error_code;
    } out_beat_t;

    function automatic logic is_hex(input logic [7:0] c);
        return (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c inside {[8'h30:8'h39]})
        begin
            v = c[3:0];
        end
        else if (c inside {[8'h41:8'h46], [8'h61:8'h66]})
        begin
            v = c[3:0] + 4'd9;
        end
        return v;
    endfunction

endpackage

FILE: rtl/http_chunked_body_decoder.sv
// Top level of the HTTP/1.1 chunked transfer body decoder.
//
// Usage: raw body bytes enter on the byte channel (byte_valid/byte_ready,
// payload byte_data), one byte per beat. Every accepted beat yields exactly
// one result beat on the res channel (res_valid/res_ready, payload res_data):
// a framing byte consumed, a payload byte (with chunk_last on the final byte
// of a chunk), body complete, or an error with its code.
// A result is registered at the edge that accepts its byte. Throughput is
// one byte per cycle when not stalled; the whole parse step (hex digit
// accumulate, byte counter decrement, limit compare) sits between the input
// port and the result register. A new byte is taken whenever the result
// register is empty or is being drained in the same cycle, so a stalled
// receiver holds the result and stops input only while it stalls.
// Reset puts the parser at the start of a size line, sets max_chunk_size to
// all ones and strict_crlf to one. start_message restarts parsing before its
// byte. Registers sit on an APB port: max_chunk_size at 0x0, strict_crlf at
// 0x4; pready is always high.
module http_chunked_body_decoder #(
    parameter int SIZE_BITS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 byte_valid,
    output logic                 byte_ready,
    input  hcbd_pkg::in_beat_t   byte_data,
    output logic                 res_valid,
    input  logic                 res_ready,
    output hcbd_pkg::out_beat_t  res_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int CMP_W = (SIZE_BITS > 32) ? SIZE_BITS : 32;

    logic [3:0]           phase_reg, phase_next;
    logic [SIZE_BITS-1:0] size_reg, size_next;
    logic [SIZE_BITS-1:0] left_reg, left_next;
    logic                 tre_reg, tre_next;
    logic [31:0]          max_reg;
    logic                 strict_reg;
    logic                 res_valid_reg;
    hcbd_pkg::out_beat_t  res_reg, res_next;
    logic                 accept;

    // Handshake
    assign byte_ready = !res_valid_reg || res_ready;
    assign accept     = byte_valid && byte_ready;
    assign res_valid  = res_valid_reg;
    assign res_data   = res_reg;

    // Configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == hcbd_pkg::REG_STRICT) ? {31'd0, strict_reg} : max_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg    <= 32'hFFFF_FFFF;
            strict_reg <= 1'b1;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2] == hcbd_pkg::REG_MAX_SIZE)
            begin
                max_reg <= pwdata;
            end
            else
            begin
                strict_reg <= pwdata[0];
            end
        end
    end

    // Parse step for one byte
    always_comb
    begin
        logic [7:0]           c;
        logic [3:0]           ph;
        logic [SIZE_BITS-1:0] sz;
        logic [SIZE_BITS-1:0] lft;
        logic                 tre;
        logic [2:0]           err;
        logic                 hdr_done;
        logic                 lf_ends;
        logic                 ws;

        c        = byte_data.data_byte;
        ph       = byte_data.start_message ? hcbd_pkg::PH_PRE : phase_reg;
        sz       = byte_data.start_message ? '0 : size_reg;
        lft      = byte_data.start_message ? '0 : left_reg;
        tre      = byte_data.start_message ? 1'b1 : tre_reg;
        err      = hcbd_pkg::E_NONE;
        hdr_done = 1'b0;
        lf_ends  = 1'b0;
        ws       = (c == hcbd_pkg::CH_SP) || (c == hcbd_pkg::CH_TAB);

        res_next.kind       = hcbd_pkg::K_FRAME;
        res_next.payload    = 8'd0;
        res_next.chunk_last = 1'b0;
        res_next.error_code = hcbd_pkg::E_NONE;

        if (ph > hcbd_pkg::PH_DONE)
        begin
            res_next.kind       = hcbd_pkg::K_ERR;
            res_next.error_code = 3'(ph - hcbd_pkg::PH_ERR0);
        end
        else if (ph == hcbd_pkg::PH_DONE)
        begin
            res_next.kind = hcbd_pkg::K_DONE;
        end
        else if (byte_data.stream_end)
        begin
            err = hcbd_pkg::E_END;
        end
        else if (ph <= hcbd_pkg::PH_HCR)
        begin
            // size line
            if (ph == hcbd_pkg::PH_HCR)
            begin
                if (c == hcbd_pkg::CH_LF) hdr_done = 1'b1;
                else err = hcbd_pkg::E_HDR;
            end
            else if (c == hcbd_pkg::CH_CR)
            begin
                if (ph == hcbd_pkg::PH_PRE) err = hcbd_pkg::E_HDR;
                else ph = hcbd_pkg::PH_HCR;
            end
            else if (c == hcbd_pkg::CH_LF)
            begin
                if (ph == hcbd_pkg::PH_PRE || strict_reg) err = hcbd_pkg::E_HDR;
                else hdr_done = 1'b1;
            end
            else if (ph == hcbd_pkg::PH_EXT)
            begin
                ph = hcbd_pkg::PH_EXT;
            end
            else if (c == hcbd_pkg::CH_SEMI)
            begin
                if (ph == hcbd_pkg::PH_PRE) err = hcbd_pkg::E_HDR;
                else ph = hcbd_pkg::PH_EXT;
            end
            else if (ws)
            begin
                if (ph == hcbd_pkg::PH_DIG) ph = hcbd_pkg::PH_POST;
            end
            else if (hcbd_pkg::is_hex(c) &&
                     (ph == hcbd_pkg::PH_PRE || ph == hcbd_pkg::PH_DIG))
            begin
                if (sz[SIZE_BITS-1 -: 4] != 4'd0)
                begin
                    err = hcbd_pkg::E_SIZE;
                end
                else
                begin
                    sz = {sz[SIZE_BITS-5:0], hcbd_pkg::hex_val(c)};
                    ph = hcbd_pkg::PH_DIG;
                end
            end
            else
            begin
                err = hcbd_pkg::E_HDR;
            end

            // end of size line: limit check and next phase
            if (hdr_done)
            begin
                if (CMP_W'(sz) > CMP_W'(max_reg))
                begin
                    err = hcbd_pkg::E_SIZE;
                end
                else if (sz == '0)
                begin
                    tre = 1'b1;
                    ph  = hcbd_pkg::PH_TRL;
                end
                else
                begin
                    lft = sz;
                    ph  = hcbd_pkg::PH_DATA;
                end
            end
        end
        else if (ph == hcbd_pkg::PH_DATA)
        begin
            res_next.kind    = hcbd_pkg::K_DATA;
            res_next.payload = c;
            lft = lft - SIZE_BITS'(1);
            if (lft == '0)
            begin
                res_next.chunk_last = 1'b1;
                ph = hcbd_pkg::PH_DCR;
            end
        end
        else if (ph == hcbd_pkg::PH_DCR)
        begin
            if (c == hcbd_pkg::CH_CR) ph = hcbd_pkg::PH_DLF;
            else err = hcbd_pkg::E_CRLF;
        end
        else if (ph == hcbd_pkg::PH_DLF)
        begin
            if (c == hcbd_pkg::CH_LF)
            begin
                sz = '0;
                ph = hcbd_pkg::PH_PRE;
            end
            else
            begin
                err = hcbd_pkg::E_CRLF;
            end
        end
        else
        begin
            // trailer lines
            if (ph == hcbd_pkg::PH_TCR)
            begin
                if (c == hcbd_pkg::CH_LF) lf_ends = 1'b1;
                else err = hcbd_pkg::E_HDR;
            end
            else if (c == hcbd_pkg::CH_CR)
            begin
                ph = hcbd_pkg::PH_TCR;
            end
            else if (c == hcbd_pkg::CH_LF)
            begin
                if (strict_reg) err = hcbd_pkg::E_HDR;
                else lf_ends = 1'b1;
            end
            else
            begin
                tre = 1'b0;
            end
            if (lf_ends)
            begin
                if (tre)
                begin
                    ph = hcbd_pkg::PH_DONE;
                    res_next.kind = hcbd_pkg::K_DONE;
                end
                else
                begin
                    tre = 1'b1;
                    ph  = hcbd_pkg::PH_TRL;
                end
            end
        end

        // a fault parks the parser in its error phase
        if (err != hcbd_pkg::E_NONE)
        begin
            ph = hcbd_pkg::PH_ERR0 + {1'b0, err};
            res_next.kind       = hcbd_pkg::K_ERR;
            res_next.error_code = err;
        end

        phase_next = ph;
        size_next  = sz;
        left_next  = lft;
        tre_next   = tre;
    end

    // Parser state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= hcbd_pkg::PH_PRE;
            size_reg      <= '0;
            left_reg      <= '0;
            tre_reg       <= 1'b1;
            res_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            size_reg      <= size_next;
            left_reg      <= left_next;
            tre_reg       <= tre_next;
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

    // Checks
    a_ready_rule: assert property (@(posedge clk) disable iff (!rst_n)
        byte_ready == (!res_valid_reg || res_ready))
        else $error("byte_ready does not follow result register occupancy");

    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && phase_reg > hcbd_pkg::PH_DONE && !byte_data.start_message)
        |=> (res_valid && res_data.kind == hcbd_pkg::K_ERR))
        else $error("held error not reported");

    a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> ((res_data.kind == hcbd_pkg::K_ERR) ==
                       (res_data.error_code != hcbd_pkg::E_NONE)))
        else $error("error code and kind disagree");

    a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_data.kind != hcbd_pkg::K_DATA)
        |-> (res_data.payload == 8'd0 && !res_data.chunk_last))
        else $error("payload fields set on a non-data result");

    a_last_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && res_next.chunk_last) |=> (phase_reg == hcbd_pkg::PH_DCR))
        else $error("last chunk byte did not move to data CRLF check");

endmodule

FILE: tb/http_chunked_body_decoder_tb.sv
// Self-checking testbench for the HTTP chunked body decoder, with random chunked bodies.
module http_chunked_body_decoder_tb;

    localparam int unsigned LIMIT_CYCLES = 1000000;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam logic [2:0]  ADDR_MAX_SIZE = {hcbd_pkg::REG_MAX_SIZE, 2'b00};
    localparam logic [2:0]  ADDR_STRICT   = {hcbd_pkg::REG_STRICT, 2'b00};

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                byte_valid = 1'b0;
    logic                byte_ready;
    hcbd_pkg::in_beat_t  byte_data = '0;
    logic                res_valid;
    logic                res_ready = 1'b0;
    hcbd_pkg::out_beat_t res_data;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [2:0]          paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;

    http_chunked_body_decoder #(.SIZE_BITS(32)) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_data  (byte_data),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_data   (res_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #10 clk = ~clk;

    // Stimulus and scoreboard storage
    hcbd_pkg::in_beat_t  tx_bytes[$];
    hcbd_pkg::in_beat_t  msg[$];
    hcbd_pkg::out_beat_t pending_results[$];
    int unsigned errors = 0;
    int unsigned cycles = 0;
    int unsigned live_items = 0;
    int unsigned tx_gap = 0;
    int unsigned rx_gap = 0;
    int unsigned hold_left = 0;
    logic        hold_start = 1'b0;
    logic        tx_idle_on = 1'b0;
    logic        rx_idle_on = 1'b0;
    logic        in_fire = 1'b0;

    // Decoder shadow: configuration and parse state
    logic [31:0] cfg_max = 32'hFFFF_FFFF;
    logic        cfg_strict = 1'b1;
    logic [3:0]  ph = hcbd_pkg::PH_PRE;
    logic [31:0] csize = '0;
    logic [31:0] data_left = '0;
    logic        trl_empty = 1'b1;

    // Size line complete: enforce the limit, then go to data or trailer
    function automatic logic [2:0] size_line_done();
        if (csize > cfg_max)
            return hcbd_pkg::E_SIZE;
        if (csize == 0)
        begin
            trl_empty = 1'b1;
            ph = hcbd_pkg::PH_TRL;
        end
        else
        begin
            data_left = csize;
            ph = hcbd_pkg::PH_DATA;
        end
        return hcbd_pkg::E_NONE;
    endfunction

    // Advance the shadow parser by one byte beat and return its result beat
    function automatic hcbd_pkg::out_beat_t decode_byte(input hcbd_pkg::in_beat_t b);
        hcbd_pkg::out_beat_t r;
        logic [7:0]          c;
        logic [2:0]          err;
        int                  hv;
        logic                line_end;
        r = '0;
        c = b.data_byte;
        err = hcbd_pkg::E_NONE;
        line_end = 1'b0;
        hv = -1;
        if (c >= "0" && c <= "9")
            hv = int'(c) - 48;
        else if (c >= "a" && c <= "f")
            hv = int'(c) - 87;
        else if (c >= "A" && c <= "F")
            hv = int'(c) - 55;

        if (b.start_message)
        begin
            ph = hcbd_pkg::PH_PRE;
            csize = '0;
            data_left = '0;
            trl_empty = 1'b1;
        end

        if (ph > hcbd_pkg::PH_DONE)
            err = 3'(ph - hcbd_pkg::PH_ERR0);
        else if (ph == hcbd_pkg::PH_DONE)
            r.kind = hcbd_pkg::K_DONE;
        else if (b.stream_end)
            err = hcbd_pkg::E_END;
        else if (ph <= hcbd_pkg::PH_HCR)
        begin
            // size line
            if (ph == hcbd_pkg::PH_HCR)
                err = (c == hcbd_pkg::CH_LF) ? size_line_done() : hcbd_pkg::E_HDR;
            else if (c == hcbd_pkg::CH_CR)
            begin
                if (ph == hcbd_pkg::PH_PRE)
                    err = hcbd_pkg::E_HDR;
                else
                    ph = hcbd_pkg::PH_HCR;
            end
            else if (c == hcbd_pkg::CH_LF)
            begin
                if (ph == hcbd_pkg::PH_PRE || cfg_strict)
                    err = hcbd_pkg::E_HDR;
                else
                    err = size_line_done();
            end
            else if (ph == hcbd_pkg::PH_EXT)
            begin
                // extension text is skipped
            end
            else if (c == hcbd_pkg::CH_SEMI)
            begin
                if (ph == hcbd_pkg::PH_PRE)
                    err = hcbd_pkg::E_HDR;
                else
                    ph = hcbd_pkg::PH_EXT;
            end
            else if (c == hcbd_pkg::CH_SP || c == hcbd_pkg::CH_TAB)
            begin
                if (ph == hcbd_pkg::PH_DIG)
                    ph = hcbd_pkg::PH_POST;
            end
            else if (hv >= 0 && (ph == hcbd_pkg::PH_PRE || ph == hcbd_pkg::PH_DIG))
            begin
                if (csize[31:28] != 4'd0)
                    err = hcbd_pkg::E_SIZE;
                else
                begin
                    csize = {csize[27:0], 4'(hv)};
                    ph = hcbd_pkg::PH_DIG;
                end
            end
            else
                err = hcbd_pkg::E_HDR;
        end
        else if (ph == hcbd_pkg::PH_DATA)
        begin
            r.kind = hcbd_pkg::K_DATA;
            r.payload = c;
            data_left = data_left - 32'd1;
            if (data_left == 0)
            begin
                r.chunk_last = 1'b1;
                ph = hcbd_pkg::PH_DCR;
            end
        end
        else if (ph == hcbd_pkg::PH_DCR)
        begin
            if (c == hcbd_pkg::CH_CR)
                ph = hcbd_pkg::PH_DLF;
            else
                err = hcbd_pkg::E_CRLF;
        end
        else if (ph == hcbd_pkg::PH_DLF)
        begin
            if (c == hcbd_pkg::CH_LF)
            begin
                csize = '0;
                ph = hcbd_pkg::PH_PRE;
            end
            else
                err = hcbd_pkg::E_CRLF;
        end
        else
        begin
            // trailer lines, ended by an empty line
            if (ph == hcbd_pkg::PH_TCR)
            begin
                if (c == hcbd_pkg::CH_LF)
                    line_end = 1'b1;
                else
                    err = hcbd_pkg::E_HDR;
            end
            else if (c == hcbd_pkg::CH_CR)
                ph = hcbd_pkg::PH_TCR;
            else if (c == hcbd_pkg::CH_LF)
            begin
                if (cfg_strict)
                    err = hcbd_pkg::E_HDR;
                else
                    line_end = 1'b1;
            end
            else
                trl_empty = 1'b0;
            if (line_end)
            begin
                if (trl_empty)
                begin
                    ph = hcbd_pkg::PH_DONE;
                    r.kind = hcbd_pkg::K_DONE;
                end
                else
                begin
                    trl_empty = 1'b1;
                    ph = hcbd_pkg::PH_TRL;
                end
            end
        end

        if (err != hcbd_pkg::E_NONE)
        begin
            r.kind = hcbd_pkg::K_ERR;
            r.error_code = err;
            ph = hcbd_pkg::PH_ERR0 + {1'b0, err};
        end
        return r;
    endfunction

    // Idle gap length: mostly short, now and then long
    function automatic int unsigned rand_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    function automatic logic [7:0] rand_text_byte();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c == hcbd_pkg::CH_CR || c == hcbd_pkg::CH_LF);
        return c;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v, input logic upper);
        if (v < 4'd10)
            return "0" + {4'd0, v};
        return (upper ? "A" : "a") + {4'd0, v} - 8'd10;
    endfunction

    task automatic note_error(input string what, input int unsigned want, input int unsigned got);
        errors++;
        if (errors <= 10)
            $display("mismatch %s: expected 0x%0h, got 0x%0h", what, want, got);
    endtask

    task automatic put_beat(input logic [7:0] c, input logic se = 1'b0, input logic sm = 1'b0);
        hcbd_pkg::in_beat_t b;
        b.data_byte = c;
        b.stream_end = se;
        b.start_message = sm;
        msg.insert(msg.size(), b);
    endtask

    task automatic flush_msg();
        foreach (msg[i])
            tx_bytes.insert(tx_bytes.size(), msg[i]);
        msg.delete();
    endtask

    task automatic put_ws();
        repeat ($urandom_range(1, 2))
            put_beat($urandom_range(0, 1) ? hcbd_pkg::CH_SP : hcbd_pkg::CH_TAB);
    endtask

    // CRLF, a bare LF where allowed, and rarely a refused bare LF
    task automatic put_line_end();
        if (!cfg_strict && $urandom_range(0, 2) == 0)
            put_beat(hcbd_pkg::CH_LF);
        else if (cfg_strict && $urandom_range(0, 39) == 0)
            put_beat(hcbd_pkg::CH_LF);
        else
        begin
            put_beat(hcbd_pkg::CH_CR);
            put_beat(hcbd_pkg::CH_LF);
        end
    endtask

    // Size line; a wide one stops right after the overflowing digit
    task automatic put_size_line(input logic [31:0] size, input logic wide);
        int   n;
        logic up;
        up = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 4) == 0)
            put_ws();
        if (wide)
        begin
            put_beat(hex_char(4'($urandom_range(1, 15)), up));
            size = $urandom;
            n = 8;
        end
        else
        begin
            if ($urandom_range(0, 7) == 0)
                repeat ($urandom_range(1, 9))
                    put_beat("0");
            n = 1;
            while (n < 8 && (size >> (4 * n)) != 0)
                n++;
        end
        for (int i = n - 1; i >= 0; i--)
            put_beat(hex_char(size[4 * i +: 4], up));
        if (wide)
            return;
        if ($urandom_range(0, 4) == 0)
            put_ws();
        if ($urandom_range(0, 4) == 0)
        begin
            put_beat(hcbd_pkg::CH_SEMI);
            repeat ($urandom_range(0, 4))
                put_beat(rand_text_byte());
        end
        put_line_end();
    endtask

    // One chunked body, well formed or broken at a random spot
    task automatic gen_message();
        int                 nch;
        int                 p;
        int                 mode;
        logic [31:0]        sz;
        logic               broken;
        logic               cut;
        hcbd_pkg::in_beat_t b;
        msg.delete();
        broken = ($urandom_range(0, 4) == 0);
        cut = 1'b0;
        nch = $urandom_range(0, 3);
        for (int k = 0; k < nch && !cut; k++)
        begin
            mode = $urandom_range(0, 19);
            if (mode == 0)
            begin
                put_size_line(32'h0, 1'b1);
                cut = 1'b1;
            end
            else if (cfg_max == 0 || (mode == 1 && cfg_max < 32'h40))
            begin
                put_size_line(cfg_max + $urandom_range(1, 3), 1'b0);
                cut = 1'b1;
            end
            else
            begin
                sz = (mode < 4) ? $urandom_range(7, 40) : $urandom_range(1, 6);
                if (sz > cfg_max)
                    sz = cfg_max;
                put_size_line(sz, 1'b0);
                repeat (sz)
                    put_beat(8'($urandom_range(0, 255)));
                put_beat(hcbd_pkg::CH_CR);
                put_beat(hcbd_pkg::CH_LF);
            end
        end
        if (!cut)
        begin
            put_size_line(32'h0, 1'b0);
            repeat ($urandom_range(0, 2))
            begin
                repeat ($urandom_range(1, 5))
                    put_beat(rand_text_byte());
                put_line_end();
            end
            put_line_end();
            // beats after completion
            if ($urandom_range(0, 3) == 0)
                put_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
        msg[0].start_message = 1'b1;
        p = msg.size();
        if (broken && msg.size() > 1)
        begin
            p = $urandom_range(1, msg.size() - 1);
            case ($urandom_range(0, 2))
                0: msg[p].data_byte = 8'($urandom_range(0, 255));
                1:
                begin
                    while (msg.size() > p)
                        msg.delete(msg.size() - 1);
                    put_beat(8'($urandom_range(0, 255)), 1'b1);
                end
                default:
                begin
                    b.data_byte = 8'($urandom_range(0, 255));
                    b.stream_end = 1'b0;
                    b.start_message = 1'b0;
                    msg.insert(p, b);
                end
            endcase
            p = p + 1;
        end
        live_items += p;
        flush_msg();
    endtask

    // Short burst of raw bytes with random flags
    task automatic gen_noise();
        repeat ($urandom_range(1, 6))
            put_beat(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0,
                     $urandom_range(0, 5) == 0);
        live_items += 1;
        flush_msg();
    endtask

    task automatic wait_drained();
        while (tx_bytes.size() != 0 || byte_valid || pending_results.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // APB write: setup, then access; pready is tied high
    task automatic reg_write(input logic [2:0] addr, input logic [31:0] val);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (addr == ADDR_MAX_SIZE)
            cfg_max = val;
        else
            cfg_strict = val[0];
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic run_phase(input logic [31:0] lim, input logic strict, input logic idle,
                             input int unsigned n, input logic hold);
        int unsigned stop;
        wait_drained();
        reg_write(ADDR_MAX_SIZE, lim);
        reg_write(ADDR_STRICT, {31'd0, strict});
        tx_idle_on = idle;
        rx_idle_on = idle;
        if (hold)
        begin
            @(posedge clk);
            hold_start = 1'b1;
            @(posedge clk);
            hold_start = 1'b0;
        end
        stop = live_items + n;
        while (live_items < stop)
        begin
            if ($urandom_range(0, 9) == 0)
                gen_noise();
            else
                gen_message();
        end
    endtask

    // Byte driver: next beat once the current one is taken
    always @(negedge clk)
    begin : drive_bytes
        logic               nv;
        hcbd_pkg::in_beat_t nd;
        nv = byte_valid;
        nd = byte_data;
        if (!byte_valid || in_fire)
        begin
            if (tx_gap != 0)
            begin
                tx_gap--;
                nv = 1'b0;
            end
            else if (rst_n && tx_bytes.size() != 0)
            begin
                nd = tx_bytes.pop_front();
                nv = 1'b1;
                if (tx_idle_on && $urandom_range(0, 2) == 0)
                    tx_gap = rand_gap();
            end
            else
                nv = 1'b0;
        end
        byte_valid <= nv;
        byte_data <= nd;
    end

    // Long receiver hold-off, counted here
    always @(negedge clk)
    begin
        if (hold_start)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Result receiver with random stalls
    always @(negedge clk)
    begin
        if (rx_gap != 0)
        begin
            rx_gap--;
            res_ready <= 1'b0;
        end
        else if (hold_left != 0)
            res_ready <= 1'b0;
        else
        begin
            res_ready <= 1'b1;
            if (rx_idle_on && $urandom_range(0, 2) == 0)
                rx_gap = rand_gap();
        end
    end

    // Monitor: check result beats, predict on accepted byte beats
    always @(posedge clk)
    begin : monitor
        hcbd_pkg::out_beat_t want;
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
        begin
            if (rst_n && res_valid && res_ready)
            begin
                if (pending_results.size() == 0)
                    note_error("unexpected result", 0, 32'(res_data));
                else
                begin
                    want = pending_results.pop_front();
                    if (res_data.kind !== want.kind)
                        note_error("kind", 32'(want.kind), 32'(res_data.kind));
                    if (res_data.payload !== want.payload)
                        note_error("payload", 32'(want.payload), 32'(res_data.payload));
                    if (res_data.chunk_last !== want.chunk_last)
                        note_error("chunk_last", 32'(want.chunk_last),
                                   32'(res_data.chunk_last));
                    if (res_data.error_code !== want.error_code)
                        note_error("error_code", 32'(want.error_code),
                                   32'(res_data.error_code));
                end
            end
            if (rst_n && byte_valid && byte_ready)
                pending_results.insert(pending_results.size(), decode_byte(byte_data));
            in_fire <= rst_n && byte_valid && byte_ready;
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: full body with extension, trailer and beats after completion
        put_beat("2", 1'b0, 1'b1);
        put_beat(hcbd_pkg::CH_SEMI);
        put_beat(hcbd_pkg::CH_CR);
        put_beat(hcbd_pkg::CH_LF);
        put_beat(8'h00);
        put_beat(8'hFF);
        put_beat(hcbd_pkg::CH_CR);
        put_beat(hcbd_pkg::CH_LF);
        put_beat("0");
        put_beat(hcbd_pkg::CH_SP);
        put_beat(hcbd_pkg::CH_CR);
        put_beat(hcbd_pkg::CH_LF);
        put_beat("T");
        put_beat(hcbd_pkg::CH_CR);
        put_beat(hcbd_pkg::CH_LF);
        put_beat(hcbd_pkg::CH_CR);
        put_beat(hcbd_pkg::CH_LF);
        put_beat("z");
        put_beat(8'h00, 1'b1);
        // empty size line
        put_beat(hcbd_pkg::CH_CR, 1'b0, 1'b1);
        // junk in size line
        put_beat("G", 1'b0, 1'b1);
        // CR without LF, then the error is held
        put_beat("c", 1'b0, 1'b1);
        put_beat(hcbd_pkg::CH_CR);
        put_beat("x");
        put_beat("y");
        // bare LF while strict
        put_beat("1", 1'b0, 1'b1);
        put_beat(hcbd_pkg::CH_LF);
        // stream ends mid size line
        put_beat("f", 1'b0, 1'b1);
        put_beat(8'hA5, 1'b1);
        flush_msg();

        // Random phases over several register settings
        run_phase(32'hFFFF_FFFF, 1'b0, 1'b1, 230, 1'b0);
        run_phase(32'h0, 1'b1, 1'b1, 150, 1'b0);
        run_phase(32'h10, 1'b0, 1'b1, 230, 1'b0);
        run_phase($urandom_range(1, 200), 1'b1, 1'b1, 230, 1'b0);
        run_phase(32'hFFFF_FFFF, 1'b1, 1'b0, 230, 1'b1);
        run_phase(32'h8, 1'b1, 1'b0, 200, 1'b0);

        wait_drained();
        repeat (5) @(posedge clk);
        if (pending_results.size() != 0)
            note_error("results still outstanding", 0, 32'(pending_results.size()));
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: http_chunked_body_decoder.f
rtl/hcbd_pkg.sv
rtl/http_chunked_body_decoder.sv
tb/http_chunked_body_decoder_tb.sv
